// ===== design/pixel_run_length_encoder_top_defines.svh =====
// Assertion macros shared by the pixel run-length encoder modules.
`ifndef PIXEL_RUN_LENGTH_ENCODER_TOP_DEFINES_SVH
`define PIXEL_RUN_LENGTH_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PRLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PRLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/prle_pkg.sv =====
// Types, constants and run coding function for the pixel run-length encoder.
`default_nettype none

package prle_pkg;

    localparam logic [5:0] RUN_MAX    = 6'd63;
    localparam logic [7:0] RUN_BASE   = 8'd192;
    localparam logic [7:0] SINGLE_ESC = 8'd193;
    localparam logic [7:0] ESC_LIMIT  = 8'd63;

    // Coded form of one closed run: zero, one or two bytes.
    typedef struct packed {
        logic [1:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_run_code;

    // Every byte that one pixel word causes, in stream order.
    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
        logic            frame_end;
    } t_burst;

    function automatic t_run_code code_run(input logic [7:0] value, input logic [5:0] count);
        t_run_code rc;
        rc.len = 2'd0;
        rc.b0  = value;
        rc.b1  = value;
        if (count == 6'd1) begin
            if (value > ESC_LIMIT) begin
                rc.len = 2'd2;
                rc.b0  = SINGLE_ESC;
            end else begin
                rc.len = 2'd1;
            end
        end else if (count != 6'd0) begin
            rc.len = 2'd2;
            rc.b0  = RUN_BASE + {2'b00, count};
        end
        return rc;
    endfunction

endpackage

`default_nettype wire

// ===== design/prle_encoder.sv =====
// Run tracking and byte burst formation for the pixel run-length encoder.
`default_nettype none

module prle_encoder
    import prle_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_pixel,
    input  wire logic       i_frame_last,
    output t_burst          o_burst
);

`include "pixel_run_length_encoder_top_defines.svh"

    logic [7:0] r_value;
    logic [5:0] r_count;
    logic [7:0] n_value;
    logic [5:0] n_count;

    logic       brk;
    logic       open_new;
    logic [5:0] grown;
    logic       close_run;
    t_run_code  code_old;
    t_run_code  code_new;

    always_comb begin
        brk       = (r_count != 6'd0) && (i_pixel != r_value);
        open_new  = (r_count == 6'd0) || brk;
        grown     = open_new ? 6'd1 : (r_count + 6'd1);
        n_value   = open_new ? i_pixel : r_value;
        close_run = (grown == RUN_MAX) || i_frame_last;
        n_count   = close_run ? 6'd0 : grown;
        code_old  = code_run(r_value, brk ? r_count : 6'd0);
        code_new  = code_run(n_value, close_run ? grown : 6'd0);
    end

    // The old run goes out first, the new or extended run packs in behind it.
    always_comb begin
        o_burst.len       = {1'b0, code_old.len} + {1'b0, code_new.len};
        o_burst.frame_end = i_frame_last;
        unique case (code_old.len)
            2'd2:    o_burst.bytes = {code_new.b1, code_new.b0, code_old.b1, code_old.b0};
            2'd1:    o_burst.bytes = {code_new.b1, code_new.b1, code_new.b0, code_old.b0};
            default: o_burst.bytes = {code_new.b1, code_new.b1, code_new.b1, code_new.b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= 8'd0;
            r_count <= 6'd0;
        end else if (i_accept) begin
            r_value <= n_value;
            r_count <= n_count;
        end
    end

    `PRLE_ASSERT_NOW(a_frame_end_emits, i_clk, i_rst_n, i_accept && i_frame_last, o_burst.len != 3'd0, "frame end word produced no bytes")
    `PRLE_ASSERT_NEXT(a_frame_end_closes, i_clk, i_rst_n, i_accept && i_frame_last, r_count == 6'd0, "run left open after frame end")
    `PRLE_ASSERT_NOW(a_count_below_max, i_clk, i_rst_n, 1'b1, r_count < RUN_MAX, "open run reached full length")

endmodule

`default_nettype wire

// ===== design/prle_burst.sv =====
// Burst register that hands out one coded byte per cycle while the output does not stall.
`default_nettype none

module prle_burst
    import prle_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_burst     i_burst,
    output logic            o_ready,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_code_byte,
    output logic            o_item_last,
    output logic            o_stream_end
);

`include "pixel_run_length_encoder_top_defines.svh"

    logic [3:0][7:0] r_bytes;
    logic            r_end;
    logic [2:0]      r_left;
    logic [1:0]      r_rd;
    logic            take;

    always_comb begin
        o_valid      = (r_left != 3'd0);
        take         = o_valid && !i_stall;
        o_ready      = (r_left == 3'd0) || ((r_left == 3'd1) && !i_stall);
        o_code_byte  = r_bytes[r_rd];
        o_item_last  = (r_left == 3'd1);
        o_stream_end = (r_left == 3'd1) && r_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_rd   <= 2'd0;
        end else if (i_load) begin
            r_left <= i_burst.len;
            r_rd   <= 2'd0;
        end else if (take) begin
            r_left <= r_left - 3'd1;
            r_rd   <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
            r_end   <= i_burst.frame_end;
        end
    end

    `PRLE_ASSERT_NOW(a_load_fits, i_clk, i_rst_n, i_load, o_ready && (i_burst.len != 3'd0) && (i_burst.len <= 3'd4), "burst loaded while busy or with bad length")
    `PRLE_ASSERT_NOW(a_left_bounded, i_clk, i_rst_n, 1'b1, r_left <= 3'd4, "burst byte count out of range")
    `PRLE_ASSERT_NEXT(a_drain_empties, i_clk, i_rst_n, take && (r_left == 3'd1) && !i_load, !o_valid, "burst still valid after its last word")

endmodule

`default_nettype wire

// ===== design/pixel_run_length_encoder_top.sv =====
// Top level of the pixel run-length encoder.
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_pixel, i_frame_last
// output    out        o_valid / i_stall    o_code_byte, o_item_last, o_stream_end
//
// A pixel word is taken in any cycle without input stall and its bytes appear on the
// output the next cycle, one byte per cycle from a four-byte burst register unless the
// output stalls. A pixel that causes no bytes does not hold the input; one that causes
// bytes holds it until its last byte leaves, two bytes at most except at a frame end.
// Reset clears the open run and empties the burst register.
// Input stall is high while the burst register holds bytes, unless its last byte leaves now.

module pixel_run_length_encoder_top
    import prle_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_pixel,
    input  wire logic       i_frame_last,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_code_byte,
    output logic            o_item_last,
    output logic            o_stream_end
);

    logic   accept;
    logic   burst_ready;
    t_burst burst;

    // A word is taken whenever the burst register can take its bytes.
    assign o_stall = !burst_ready;
    assign accept  = i_valid && burst_ready;

    // Run state updates for every accepted word; the burst comes straight
    // out of combinational coding on the incoming pixel.
    prle_encoder u_encoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_pixel      (i_pixel),
        .i_frame_last (i_frame_last),
        .o_burst      (burst)
    );

    // Only words that cause bytes occupy the burst register.
    prle_burst u_burst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept && (burst.len != 3'd0)),
        .i_burst      (burst),
        .o_ready      (burst_ready),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_code_byte  (o_code_byte),
        .o_item_last  (o_item_last),
        .o_stream_end (o_stream_end)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the pixel run-length encoder with a run coding scoreboard.
`timescale 1ns / 100ps

module testbench;
    import prle_pkg::*;

    // One byte of the compressed stream together with its markers.
    typedef struct {
        logic [7:0] code;
        logic       item_last;
        logic       stream_end;
    } t_code_word;

    // The scoreboard tracks the open run exactly as the encoder should and keeps the
    // bytes that accepted pixels still owe the output side, oldest first.
    class run_code_board;
        logic [7:0] open_value;
        logic [5:0] open_count;
        t_code_word step_bytes[$];
        t_code_word expected_bytes[$];
        int         error_count;

        function new();
            open_value  = 8'd0;
            open_count  = 6'd0;
            error_count = 0;
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            error_count++;
        endtask

        function void push_byte(input logic [7:0] b);
            t_code_word w;
            w.code       = b;
            w.item_last  = 1'b0;
            w.stream_end = 1'b0;
            step_bytes.push_back(w);
        endfunction

        // Emits the open run, if any, and closes it.
        function void close_run();
            if (open_count == 6'd0)
                return;
            if (open_count == 6'd1) begin
                if (open_value > ESC_LIMIT)
                    push_byte(SINGLE_ESC);
            end else begin
                push_byte(RUN_BASE + {2'b00, open_count});
            end
            push_byte(open_value);
            open_count = 6'd0;
        endfunction

        // Works out the bytes that one accepted pixel causes.
        function void note_pixel(input logic [7:0] px, input logic frame_last);
            step_bytes.delete();
            if (open_count != 6'd0 && px != open_value)
                close_run();
            if (open_count == 6'd0) begin
                open_value = px;
                open_count = 6'd1;
            end else begin
                open_count = open_count + 6'd1;
            end
            if (open_count >= RUN_MAX)
                close_run();
            if (frame_last)
                close_run();
            if (step_bytes.size() > 0) begin
                step_bytes[step_bytes.size() - 1].item_last  = 1'b1;
                step_bytes[step_bytes.size() - 1].stream_end = frame_last;
            end
            foreach (step_bytes[k])
                expected_bytes.push_back(step_bytes[k]);
        endfunction

        task check_byte(input logic [7:0] code, input logic item_last, input logic stream_end);
            t_code_word w;
            if (expected_bytes.size() == 0) begin
                report($sformatf("byte %0d arrived with nothing expected", code));
                return;
            end
            w = expected_bytes.pop_front();
            if (code !== w.code)
                report($sformatf("code byte %0d, expected %0d", code, w.code));
            if (item_last !== w.item_last)
                report($sformatf("item_last %b, expected %b (byte %0d)",
                                 item_last, w.item_last, w.code));
            if (stream_end !== w.stream_end)
                report($sformatf("stream_end %b, expected %b (byte %0d)",
                                 stream_end, w.stream_end, w.code));
        endtask
    endclass

    localparam int STALL_PCT  = 27;
    localparam int HANG_LIMIT = 1000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_pixel = 8'd0;
    logic       i_frame_last = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_code_byte;
    logic       o_item_last;
    logic       o_stream_end;

    // When cleared, neither side idles; this gives a stretch at full throughput.
    logic gaps_on = 1'b1;
    int   quiet_cycles = 0;

    run_code_board board = new();

    pixel_run_length_encoder_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel      (i_pixel),
        .i_frame_last (i_frame_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_code_byte  (o_code_byte),
        .o_item_last  (o_item_last),
        .o_stream_end (o_stream_end)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The output side stalls at random, independent of what the encoder is doing.
    always @(posedge i_clk) begin
        i_stall <= gaps_on && ($urandom_range(0, 99) < STALL_PCT);
    end

    // Monitor and watchdog. All signals are read right after the edge, so they hold the
    // values that the edge itself saw. A pixel word is noted before any byte is checked,
    // although a byte can never come out in the same cycle as the pixel that caused it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                board.note_pixel(i_pixel, i_frame_last);
            if (o_valid && !i_stall)
                board.check_byte(o_code_byte, o_item_last, o_stream_end);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", HANG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Offers one pixel word, possibly after a few idle cycles, and returns at the edge
    // that accepts it. The caller drives the next word or lowers valid in that same step,
    // so valid gets only one assignment per step.
    task automatic send_pixel(input logic [7:0] px, input logic frame_last);
        while (gaps_on && $urandom_range(0, 99) < STALL_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_pixel      <= px;
        i_frame_last <= frame_last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    initial begin
        int         sent;
        int         run_len;
        int         pick;
        logic [7:0] run_val;
        logic       noisy;
        logic       fl;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Single pixels at the extremes: zero and 63 go out bare, 64 and
        // 255 need the escape byte in front.
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd63, 1'b1);
        send_pixel(8'd64, 1'b1);
        send_pixel(8'd255, 1'b1);
        // A run of two closed by the frame end.
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b1);
        // A value change flushes a run of three; the next frame end then flushes the
        // escaped single and the new pixel in one step.
        send_pixel(8'd5, 1'b0);
        send_pixel(8'd5, 1'b0);
        send_pixel(8'd5, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd0, 1'b1);
        // The largest burst: a value change and a frame end together give four bytes.
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd128, 1'b1);
        // Alternating bit patterns.
        send_pixel(8'd170, 1'b0);
        send_pixel(8'd85, 1'b0);
        send_pixel(8'd85, 1'b1);

        // Random part: runs of random value and length. Most runs are short; a few are
        // long enough to fill a run and start another of the same value. Some runs are
        // replaced by noise where every pixel is drawn on its own.
        sent = 0;
        while (sent < 400) begin
            gaps_on <= !(sent >= 150 && sent < 250);
            pick = $urandom_range(0, 99);
            if (pick < 8)
                run_len = $urandom_range(60, 130);
            else
                run_len = $urandom_range(1, 6);
            noisy = ($urandom_range(0, 99) < 15);
            case ($urandom_range(0, 3))
                0: run_val = 8'd0;
                1: run_val = 8'd63 + 8'($urandom_range(0, 1));
                2: run_val = 8'd255;
                default: run_val = 8'($urandom_range(0, 255));
            endcase
            for (int k = 0; k < run_len && sent < 400; k++) begin
                if (run_len > 6)
                    fl = (k == run_len - 1) && ($urandom_range(0, 2) == 0);
                else
                    fl = ($urandom_range(0, 29) == 0);
                send_pixel(noisy ? 8'($urandom_range(0, 255)) : run_val, fl);
                sent++;
            end
        end
        gaps_on <= 1'b1;
        // Close the frame so the last open run comes out and is checked.
        send_pixel(8'($urandom_range(0, 255)), 1'b1);
        i_valid <= 1'b0;

        while (board.expected_bytes.size() != 0)
            @(posedge i_clk);
        // A few more cycles catch any stray byte after the stream end.
        repeat (10) @(posedge i_clk);

        if (board.error_count == 0 && board.expected_bytes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/prle_pkg.sv
design/prle_encoder.sv
design/prle_burst.sv
design/pixel_run_length_encoder_top.sv
tb/testbench.sv
